// ===== rtl/core/tps_pkg.sv =====
// ----------------------------------------------------------------------------
// tps_pkg
// Types, phase codes and phase rule tables for the training phase sequencer.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int unsigned NUM_PHASES = 19;
    localparam int unsigned PHASE_W    = 5;
    localparam int unsigned FB_W       = 32;
    localparam int unsigned FIN_W      = 10;
    localparam int unsigned CTL_W      = 12;
    localparam int unsigned EN_W       = 4;
    localparam int unsigned TASK_W     = 4;
    localparam int unsigned CONS_W     = 11;
    localparam int unsigned FIN_IDX_W  = 4;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE          = 5'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT_CONST    = 5'd1;
    localparam logic [PHASE_W-1:0] PH_SEND_CONST    = 5'd2;
    localparam logic [PHASE_W-1:0] PH_WAIT_FWD      = 5'd3;
    localparam logic [PHASE_W-1:0] PH_FWD_W_INIT    = 5'd4;
    localparam logic [PHASE_W-1:0] PH_FWD_B_INIT    = 5'd5;
    localparam logic [PHASE_W-1:0] PH_FWD_X_INIT    = 5'd6;
    localparam logic [PHASE_W-1:0] PH_FWD_WORK      = 5'd7;
    localparam logic [PHASE_W-1:0] PH_SEND_NORM     = 5'd8;
    localparam logic [PHASE_W-1:0] PH_SEND_OUT      = 5'd9;
    localparam logic [PHASE_W-1:0] PH_WAIT_PARAM    = 5'd10;
    localparam logic [PHASE_W-1:0] PH_PARAM_Y_INIT  = 5'd11;
    localparam logic [PHASE_W-1:0] PH_PARAM_DZ_INIT = 5'd12;
    localparam logic [PHASE_W-1:0] PH_PARAM_WORK    = 5'd13;
    localparam logic [PHASE_W-1:0] PH_PARAM_RESULT  = 5'd14;
    localparam logic [PHASE_W-1:0] PH_WAIT_BWD     = 5'd15;
    localparam logic [PHASE_W-1:0] PH_DZ_INIT       = 5'd16;
    localparam logic [PHASE_W-1:0] PH_BWD_WORK      = 5'd17;
    localparam logic [PHASE_W-1:0] PH_SEND_RESULT   = 5'd18;

    // task codes
    localparam logic [TASK_W-1:0] TASK_NONE          = 4'd0;
    localparam logic [TASK_W-1:0] TASK_WAIT_RUN      = 4'd1;
    localparam logic [TASK_W-1:0] TASK_SEND_CONST    = 4'd2;
    localparam logic [TASK_W-1:0] TASK_FWD_W_INIT    = 4'd3;
    localparam logic [TASK_W-1:0] TASK_FWD_B_INIT    = 4'd4;
    localparam logic [TASK_W-1:0] TASK_FWD_X_INIT    = 4'd5;
    localparam logic [TASK_W-1:0] TASK_SEND_NORM     = 4'd6;
    localparam logic [TASK_W-1:0] TASK_SEND_OUT      = 4'd7;
    localparam logic [TASK_W-1:0] TASK_PARAM_Y_INIT  = 4'd8;
    localparam logic [TASK_W-1:0] TASK_PARAM_DZ_INIT = 4'd9;
    localparam logic [TASK_W-1:0] TASK_PARAM_RESULT  = 4'd10;
    localparam logic [TASK_W-1:0] TASK_DZ_INIT       = 4'd11;
    localparam logic [TASK_W-1:0] TASK_BWD_RESULT    = 4'd12;

    // how a phase is left
    localparam logic [1:0] ADV_RUN      = 2'd0;
    localparam logic [1:0] ADV_FEEDBACK = 2'd1;
    localparam logic [1:0] ADV_FINISH   = 2'd2;

    // expected feedback words
    localparam logic [FB_W-1:0] FB_CONST_ACK = 32'h0000_0001;
    localparam logic [FB_W-1:0] FB_FWD_READY = 32'h0000_0002;
    localparam logic [FB_W-1:0] FB_FWD_DONE  = 32'h0000_0010;
    localparam logic [FB_W-1:0] FB_PARAM_RDY = 32'h0000_0080;
    localparam logic [FB_W-1:0] FB_PARAM_DONE = 32'h0000_0200;
    localparam logic [FB_W-1:0] FB_BWD_READY = 32'h0000_0400;
    localparam logic [FB_W-1:0] FB_BWD_DONE  = 32'h0000_0800;

    typedef struct packed {
        logic [1:0]           kind;
        logic [FB_W-1:0]      fb_match;
        logic [FIN_IDX_W-1:0] fin_idx;
        logic                 ctl_wr;
        logic [CTL_W-1:0]     ctl;
        logic                 en_wr;
        logic [EN_W-1:0]      en;
    } t_rule;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [CTL_W-1:0]   ctl;
        logic [EN_W-1:0]    en;
    } t_seq_state;

    typedef struct packed {
        logic               done;
        logic [CONS_W-1:0]  consumed;
        logic [TASK_W-1:0]  task_sel;
        logic [PHASE_W-1:0] phase;
        logic [EN_W-1:0]    en;
        logic [CTL_W-1:0]   ctl;
    } t_result;

    function automatic t_rule mk_rule(
        input logic [1:0]           kind,
        input logic [FB_W-1:0]      fb,
        input logic [FIN_IDX_W-1:0] fin,
        input logic                 ctl_wr,
        input logic [CTL_W-1:0]     ctl,
        input logic                 en_wr,
        input logic [EN_W-1:0]      en
    );
        t_rule r;
        r.kind     = kind;
        r.fb_match = fb;
        r.fin_idx  = fin;
        r.ctl_wr   = ctl_wr;
        r.ctl      = ctl;
        r.en_wr    = en_wr;
        r.en       = en;
        return r;
    endfunction

    function automatic t_rule rule_of(input logic [PHASE_W-1:0] ph);
        t_rule r;
        case (ph)
            PH_IDLE:          r = mk_rule(ADV_RUN, '0, 4'd0, 1'b0, 12'h000, 1'b1, 4'd1);
            PH_WAIT_CONST:    r = mk_rule(ADV_FEEDBACK, FB_CONST_ACK, 4'd0,
                                          1'b0, 12'h000, 1'b1, 4'd0);
            PH_SEND_CONST:    r = mk_rule(ADV_FINISH, '0, 4'd0, 1'b1, 12'h002, 1'b0, 4'd0);
            PH_WAIT_FWD:      r = mk_rule(ADV_FEEDBACK, FB_FWD_READY, 4'd0,
                                          1'b1, 12'h000, 1'b1, 4'd0);
            PH_FWD_W_INIT:    r = mk_rule(ADV_FINISH, '0, 4'd1, 1'b1, 12'h004, 1'b0, 4'd0);
            PH_FWD_B_INIT:    r = mk_rule(ADV_FINISH, '0, 4'd2, 1'b1, 12'h008, 1'b0, 4'd0);
            PH_FWD_X_INIT:    r = mk_rule(ADV_FINISH, '0, 4'd3, 1'b1, 12'h010, 1'b0, 4'd0);
            PH_FWD_WORK:      r = mk_rule(ADV_FEEDBACK, FB_FWD_DONE, 4'd0,
                                          1'b1, 12'h000, 1'b0, 4'd0);
            PH_SEND_NORM:     r = mk_rule(ADV_FINISH, '0, 4'd4, 1'b1, 12'h020, 1'b0, 4'd0);
            PH_SEND_OUT:      r = mk_rule(ADV_FINISH, '0, 4'd5, 1'b1, 12'h040, 1'b0, 4'd0);
            PH_WAIT_PARAM:    r = mk_rule(ADV_FEEDBACK, FB_PARAM_RDY, 4'd0,
                                          1'b1, 12'h000, 1'b1, 4'd0);
            PH_PARAM_Y_INIT:  r = mk_rule(ADV_FINISH, '0, 4'd6, 1'b1, 12'h080, 1'b0, 4'd0);
            PH_PARAM_DZ_INIT: r = mk_rule(ADV_FINISH, '0, 4'd7, 1'b1, 12'h100, 1'b0, 4'd0);
            PH_PARAM_WORK:    r = mk_rule(ADV_FEEDBACK, FB_PARAM_DONE, 4'd0,
                                          1'b1, 12'h000, 1'b0, 4'd0);
            PH_PARAM_RESULT:  r = mk_rule(ADV_FINISH, '0, 4'd8, 1'b1, 12'h200, 1'b0, 4'd0);
            PH_WAIT_BWD:      r = mk_rule(ADV_FEEDBACK, FB_BWD_READY, 4'd0,
                                          1'b1, 12'h000, 1'b1, 4'd0);
            PH_DZ_INIT:       r = mk_rule(ADV_FINISH, '0, 4'd9, 1'b1, 12'h400, 1'b0, 4'd0);
            PH_BWD_WORK:      r = mk_rule(ADV_FEEDBACK, FB_BWD_DONE, 4'd0,
                                          1'b1, 12'h000, 1'b0, 4'd0);
            PH_SEND_RESULT:   r = mk_rule(ADV_FINISH, '0, 4'd8, 1'b1, 12'h800, 1'b0, 4'd0);
            default:          r = mk_rule(ADV_RUN, '0, 4'd0, 1'b0, 12'h000, 1'b0, 4'd0);
        endcase
        return r;
    endfunction

    function automatic logic [TASK_W-1:0] task_of(input logic [PHASE_W-1:0] ph);
        logic [TASK_W-1:0] t;
        case (ph)
            PH_IDLE:          t = TASK_WAIT_RUN;
            PH_SEND_CONST:    t = TASK_SEND_CONST;
            PH_FWD_W_INIT:    t = TASK_FWD_W_INIT;
            PH_FWD_B_INIT:    t = TASK_FWD_B_INIT;
            PH_FWD_X_INIT:    t = TASK_FWD_X_INIT;
            PH_SEND_NORM:     t = TASK_SEND_NORM;
            PH_SEND_OUT:      t = TASK_SEND_OUT;
            PH_PARAM_Y_INIT:  t = TASK_PARAM_Y_INIT;
            PH_PARAM_DZ_INIT: t = TASK_PARAM_DZ_INIT;
            PH_PARAM_RESULT:  t = TASK_PARAM_RESULT;
            PH_DZ_INIT:       t = TASK_DZ_INIT;
            PH_SEND_RESULT:   t = TASK_BWD_RESULT;
            default:          t = TASK_NONE;
        endcase
        return t;
    endfunction

    // enable value held while waiting on the accelerator, zero when none
    function automatic logic [EN_W-1:0] enable_in(input logic [PHASE_W-1:0] ph);
        logic [EN_W-1:0] e;
        case (ph)
            PH_WAIT_FWD:   e = 4'd2;
            PH_WAIT_PARAM: e = 4'd4;
            PH_WAIT_BWD:   e = 4'd8;
            default:       e = 4'd0;
        endcase
        return e;
    endfunction

endpackage

// ===== rtl/core/tps_step.sv =====
// ----------------------------------------------------------------------------
// tps_step
// One sequencer tick: phase advance decision, control/enable update, task pick.
// ----------------------------------------------------------------------------
module tps_step (
    input  tps_pkg::t_seq_state               i_state,
    input  logic                              i_run_request,
    input  logic [tps_pkg::FB_W-1:0]          i_feedback_word,
    input  logic [tps_pkg::FIN_W-1:0]         i_finish_events,
    output tps_pkg::t_seq_state               o_state,
    output tps_pkg::t_result                  o_result
);
    import tps_pkg::*;

    t_rule             rule;
    logic              valid_phase;
    logic              go;
    logic [CONS_W-1:0] consumed;
    logic [PHASE_W-1:0] ph_next;
    logic [CTL_W-1:0]  ctl_next;
    logic [EN_W-1:0]   en_adv;
    logic [EN_W-1:0]   en_hold;
    logic              done;

    assign rule        = rule_of(i_state.phase);
    assign valid_phase = (i_state.phase < PHASE_W'(NUM_PHASES));

    always_comb begin
        go       = 1'b0;
        consumed = '0;
        case (rule.kind)
            ADV_RUN: begin
                go       = i_run_request;
                consumed = {{(CONS_W-1){1'b0}}, i_run_request};
            end
            ADV_FEEDBACK: begin
                go = (i_feedback_word == rule.fb_match);
            end
            ADV_FINISH: begin
                go = i_finish_events[rule.fin_idx];
                if (go) begin
                    consumed = CONS_W'(1) << (rule.fin_idx + FIN_IDX_W'(1));
                end
            end
            default: begin
                go = 1'b0;
            end
        endcase
        if (!valid_phase) begin
            go       = 1'b0;
            consumed = '0;
        end
    end

    always_comb begin
        ph_next  = i_state.phase;
        ctl_next = i_state.ctl;
        en_adv   = i_state.en;
        done     = 1'b0;
        if (go) begin
            if (rule.ctl_wr) begin
                ctl_next = rule.ctl;
            end
            if (rule.en_wr) begin
                en_adv = rule.en;
            end
            if (i_state.phase == PH_SEND_RESULT) begin
                ph_next = PH_IDLE;
                done    = 1'b1;
            end else begin
                ph_next = i_state.phase + PHASE_W'(1);
            end
        end
    end

    // the forward, parameter and backward wait phases force their enable value every tick
    assign en_hold = (enable_in(ph_next) != '0) ? enable_in(ph_next) : en_adv;

    assign o_state.phase = ph_next;
    assign o_state.ctl   = ctl_next;
    assign o_state.en    = en_hold;

    assign o_result.done     = done;
    assign o_result.consumed = consumed;
    assign o_result.task_sel = valid_phase ? task_of(ph_next) : '0;
    assign o_result.phase    = ph_next;
    assign o_result.en       = en_hold;
    assign o_result.ctl      = ctl_next;

endmodule

// ===== rtl/core/training_phase_sequencer.sv =====
// ----------------------------------------------------------------------------
// training_phase_sequencer
// Steps an accelerator through constant-load, forward, parameter and backward
// passes, one phase at most per tick.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one tick per item: run request, feedback word
//   and finish event bits. The master stream returns one item per tick with
//   the control word, enable word, new phase, task to run, consumed events
//   and a done pulse when the last phase returns to idle.
//   An input passes through an input register, then the phase decode feeding
//   the result register. Throughput is one item per cycle while the receiver
//   takes each result; while a result waits, the input side keeps accepting
//   only as long as the input register is empty.
//   When the receiver stalls, the result register holds, the input register
//   fills and then tready drops until the result is taken. Phase, control
//   and enable state change only as an item moves into the result register.
//   Reset (i_rst_n low, synchronous) empties both registers and returns the
//   sequencer to idle with control and enable words cleared.
// ----------------------------------------------------------------------------
module training_phase_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] run_request, [32:1] feedback_word, [42:33] finish_events, [47:43] zero
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [11:0] control_word, [15:12] enable_word, [20:16] phase,
    // [24:21] task_select, [35:25] consumed_events, [36] report_done, [39:37] zero
    output logic [39:0] m_axis_tdata
);
    import tps_pkg::*;

    logic                r_in_valid;
    logic                r_in_run;
    logic [FB_W-1:0]     r_in_fb;
    logic [FIN_W-1:0]    r_in_fin;
    logic                r_out_valid;
    t_result             r_out;
    t_seq_state          r_state;
    t_seq_state          n_state;
    t_result             n_out;
    logic                move;
    logic                in_take;

    assign move          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || move;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    tps_step u_step (
        .i_state         (r_state),
        .i_run_request   (r_in_run),
        .i_feedback_word (r_in_fb),
        .i_finish_events (r_in_fin),
        .o_state         (n_state),
        .o_result        (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_run <= s_axis_tdata[0];
            r_in_fb  <= s_axis_tdata[32:1];
            r_in_fin <= s_axis_tdata[42:33];
        end
        if (move) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.done, r_out.consumed, r_out.task_sel,
                            r_out.phase, r_out.en, r_out.ctl};

endmodule
